>>> design/trigger_matched_event_merger_assert.svh
// Assertion macros for the trigger-matched event merger (included by tmem_back)
`ifndef TRIGGER_MATCHED_EVENT_MERGER_ASSERT_SVH
`define TRIGGER_MATCHED_EVENT_MERGER_ASSERT_SVH

// Check a property on every clock edge outside reset
`define TMEM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define TMEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/tmem_pkg.sv
// Types and constants for the trigger-matched event merger
`timescale 1ns / 1ps
package tmem_pkg;

  localparam int THR_W  = 11;
  localparam int DROP_W = 11;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 11'd1000;
  localparam logic             MODE_START_RUN  = 1'b1;
  localparam logic [1:0]       SRC_BEAM        = 2'd0;
  localparam logic [1:0]       SRC_CALO        = 2'd1;

  typedef struct packed {
    logic        mode;
    logic [1:0]  source;
    logic [31:0] trigger_number;
    logic [63:0] ts_begin;
    logic [63:0] ts_end;
    logic [31:0] payload_handle;
  } event_t;

  typedef struct packed {
    logic              matched;
    logic [31:0]       merged_trigger;
    logic [63:0]       merged_ts_begin;
    logic [63:0]       merged_ts_end;
    logic [31:0]       beam_handle;
    logic [31:0]       calo_handle;
    logic [DROP_W-1:0] beam_dropped;
    logic [DROP_W-1:0] calo_dropped;
    logic              backlog_warning;
    logic              overflow;
    logic              unknown_source;
  } result_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_BEAM,
    CMD_CALO,
    CMD_UNKNOWN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] trigger;
    logic [63:0] ts_begin;
    logic [63:0] ts_end;
    logic [31:0] handle;
  } cmd_t;

  typedef struct packed {
    logic [31:0] trigger;
    logic [63:0] ts_begin;
    logic [63:0] ts_end;
    logic [31:0] handle;
  } beam_entry_t;

  typedef struct packed {
    logic [31:0] trigger;
    logic [31:0] handle;
  } calo_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FINISH
  } back_state_t;

endpackage

>>> design/tmem_front.sv
// Front end: accept events and classify them into merge commands
`timescale 1ns / 1ps
module tmem_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             evt_valid,
  output logic             evt_ready,
  input  tmem_pkg::event_t evt,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output tmem_pkg::cmd_t   cmd
);
  import tmem_pkg::*;

  cmd_t cmd_next;

  assign evt_ready = !cmd_valid || cmd_ready;

  always_comb begin
    cmd_next.trigger  = evt.trigger_number;
    cmd_next.ts_begin = evt.ts_begin;
    cmd_next.ts_end   = evt.ts_end;
    cmd_next.handle   = evt.payload_handle;
    priority if (evt.mode == MODE_START_RUN) begin
      cmd_next.kind = CMD_CLEAR;
    end else if (evt.source == SRC_BEAM) begin
      cmd_next.kind = CMD_BEAM;
    end else if (evt.source == SRC_CALO) begin
      cmd_next.kind = CMD_CALO;
    end else begin
      cmd_next.kind = CMD_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (evt_ready) begin
      cmd_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && evt_ready) begin
      cmd <= cmd_next;
    end
  end

endmodule

>>> design/tmem_cmd_queue.sv
// Two-entry command queue between the front end and the merge engine
`timescale 1ns / 1ps
module tmem_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  tmem_pkg::cmd_t wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output tmem_pkg::cmd_t rd_cmd
);
  import tmem_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_cmd   = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

>>> design/tmem_back.sv
// Merge engine: event queues, head matching and the result register
`timescale 1ns / 1ps
`include "trigger_matched_event_merger_assert.svh"
module tmem_back #(
  parameter int QUEUE_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  tmem_pkg::cmd_t               cmd,
  input  logic [tmem_pkg::THR_W-1:0]   threshold,
  output logic                         rec_valid,
  input  logic                         rec_ready,
  output tmem_pkg::result_t            rec
);
  import tmem_pkg::*;

  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = (CW > THR_W) ? CW : THR_W;

  back_state_t state, state_next;

  beam_entry_t beam_mem [QUEUE_DEPTH];
  calo_entry_t calo_mem [QUEUE_DEPTH];
  beam_entry_t beam_rdata;
  calo_entry_t calo_rdata;
  beam_entry_t beam_wdata;
  calo_entry_t calo_wdata;
  logic        beam_we;
  logic        calo_we;

  logic [AW-1:0] beam_head, beam_head_next;
  logic [AW-1:0] beam_tail, beam_tail_next;
  logic [CW-1:0] beam_count, beam_count_next;
  logic [AW-1:0] calo_head, calo_head_next;
  logic [AW-1:0] calo_tail, calo_tail_next;
  logic [CW-1:0] calo_count, calo_count_next;

  result_t acc, acc_next;
  result_t rec_next;
  logic    rec_load;
  logic    both_busy;
  logic    backlog;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign beam_wdata = '{trigger: cmd.trigger, ts_begin: cmd.ts_begin,
                        ts_end: cmd.ts_end, handle: cmd.handle};
  assign calo_wdata = '{trigger: cmd.trigger, handle: cmd.handle};

  assign both_busy = (beam_count_next != '0) && (calo_count_next != '0);
  assign backlog   = (CMPW'(beam_count) > CMPW'(threshold)) ||
                     (CMPW'(calo_count) > CMPW'(threshold));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = both_busy ? ST_READ : ST_FINISH;
        end
      end
      ST_READ: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = both_busy ? ST_READ : ST_FINISH;
      end
      ST_FINISH: begin
        if (!rec_valid || rec_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    beam_head_next  = beam_head;
    beam_tail_next  = beam_tail;
    beam_count_next = beam_count;
    calo_head_next  = calo_head;
    calo_tail_next  = calo_tail;
    calo_count_next = calo_count;
    acc_next        = acc;
    cmd_ready       = 1'b0;
    beam_we         = 1'b0;
    calo_we         = 1'b0;
    rec_load        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_ready = 1'b1;
          acc_next  = '0;
          unique case (cmd.kind)
            CMD_CLEAR: begin
              beam_head_next  = '0;
              beam_tail_next  = '0;
              beam_count_next = '0;
              calo_head_next  = '0;
              calo_tail_next  = '0;
              calo_count_next = '0;
            end
            CMD_BEAM: begin
              if (beam_count >= CW'(QUEUE_DEPTH)) begin
                acc_next.overflow = 1'b1;
              end else begin
                beam_we         = 1'b1;
                beam_tail_next  = adv(beam_tail);
                beam_count_next = beam_count + CW'(1);
              end
            end
            CMD_CALO: begin
              if (calo_count >= CW'(QUEUE_DEPTH)) begin
                acc_next.overflow = 1'b1;
              end else begin
                calo_we         = 1'b1;
                calo_tail_next  = adv(calo_tail);
                calo_count_next = calo_count + CW'(1);
              end
            end
            CMD_UNKNOWN: begin
              acc_next.unknown_source = 1'b1;
            end
            default: begin
              acc_next.unknown_source = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
      end
      ST_CMP: begin
        if (beam_rdata.trigger > calo_rdata.trigger) begin
          calo_head_next  = adv(calo_head);
          calo_count_next = calo_count - CW'(1);
          if (acc.calo_dropped != '1) begin
            acc_next.calo_dropped = acc.calo_dropped + DROP_W'(1);
          end
        end else if (beam_rdata.trigger < calo_rdata.trigger) begin
          beam_head_next  = adv(beam_head);
          beam_count_next = beam_count - CW'(1);
          if (acc.beam_dropped != '1) begin
            acc_next.beam_dropped = acc.beam_dropped + DROP_W'(1);
          end
        end else begin
          if (!acc.matched) begin
            acc_next.matched         = 1'b1;
            acc_next.merged_trigger  = beam_rdata.trigger;
            acc_next.merged_ts_begin = beam_rdata.ts_begin;
            acc_next.merged_ts_end   = beam_rdata.ts_end;
            acc_next.beam_handle     = beam_rdata.handle;
            acc_next.calo_handle     = calo_rdata.handle;
          end
          beam_head_next  = adv(beam_head);
          beam_count_next = beam_count - CW'(1);
          calo_head_next  = adv(calo_head);
          calo_count_next = calo_count - CW'(1);
        end
      end
      ST_FINISH: begin
        rec_load = !rec_valid || rec_ready;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rec_next                 = acc;
    rec_next.backlog_warning = backlog;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      beam_head  <= '0;
      beam_tail  <= '0;
      beam_count <= '0;
      calo_head  <= '0;
      calo_tail  <= '0;
      calo_count <= '0;
      rec_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      beam_head  <= beam_head_next;
      beam_tail  <= beam_tail_next;
      beam_count <= beam_count_next;
      calo_head  <= calo_head_next;
      calo_tail  <= calo_tail_next;
      calo_count <= calo_count_next;
      if (rec_load) begin
        rec_valid <= 1'b1;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (rec_load) begin
      rec <= rec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (beam_we) begin
      beam_mem[beam_tail] <= beam_wdata;
    end
    beam_rdata <= beam_mem[beam_head];
  end

  always_ff @(posedge clk) begin
    if (calo_we) begin
      calo_mem[calo_tail] <= calo_wdata;
    end
    calo_rdata <= calo_mem[calo_head];
  end

  `TMEM_ASSERT_ALWAYS(a_idle_one_side, (state == ST_IDLE) |-> ((beam_count == '0) || (calo_count == '0)), "both queues hold entries between transactions")
  `TMEM_ASSERT_ALWAYS(a_count_bound, (beam_count <= CW'(QUEUE_DEPTH)) && (calo_count <= CW'(QUEUE_DEPTH)), "queue occupancy beyond depth")
  `TMEM_ASSERT_NEXT(a_finish_hold, (state == ST_FINISH) && rec_valid && !rec_ready, (state == ST_FINISH) && rec_valid, "result overwritten while output stalled")

endmodule

>>> design/trigger_matched_event_merger.sv
// Top level of the trigger-matched event merger
`timescale 1ns / 1ps
// Flow: an accepted event is registered in the front end, passes through the command queue and
//   is taken by the merge engine, which loads the result register in its finish state.
// The merge engine takes a new command only after the last result is loaded; each comparison
//   of the two queue heads adds a registered memory read and a compare and pop.
// Reset (rst, synchronous): empties both queues and the command queue, sets the backlog
//   threshold to 1000. Queue memories are not cleared; no clearing pass is needed.
module trigger_matched_event_merger #(
  parameter int QUEUE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [tmem_pkg::THR_W-1:0] cfg_wr_data,
  input  logic                       evt_valid,
  output logic                       evt_ready,
  input  tmem_pkg::event_t           evt,
  output logic                       rec_valid,
  input  logic                       rec_ready,
  output tmem_pkg::result_t          rec
);
  import tmem_pkg::*;

  logic [THR_W-1:0] threshold;

  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic back_valid;
  logic back_ready;
  cmd_t back_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  tmem_front u_front (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  tmem_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_cmd   (front_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_cmd   (back_cmd)
  );

  tmem_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .threshold (threshold),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

endmodule
